@@ hdl/tekf_pkg.sv @@
// ----------------------------------------------------------------------------
// tekf_pkg
// Shared widths, action codes and the request/response types of the
// serial root/divide unit used by the TDoA measurement-row builder.
// ----------------------------------------------------------------------------
package tekf_pkg;

  // Operand widths of the shared root/divide unit
  localparam int RadW  = 66;   // sum of three squared 33-bit deltas
  localparam int NumW  = 49;   // |delta| << 16
  localparam int DistW = 34;   // floor(sqrt(radicand))

  // Input item actions
  localparam logic [1:0] ACT_LOAD_RX    = 2'd0;
  localparam logic [1:0] ACT_LOAD_PRIOR = 2'd1;
  localparam logic [1:0] ACT_LOAD_POST  = 2'd2;
  localparam logic [1:0] ACT_COMPUTE    = 2'd3;

  // Configuration register indexes
  localparam logic CFG_RANGE_VAR = 1'b0;
  localparam logic CFG_DEPTH_VAR = 1'b1;

  typedef enum logic {OP_SQRT, OP_DIV} rd_op_t;

  typedef struct packed {
    logic              start;
    rd_op_t            op;
    logic [RadW-1:0]   rad;
    logic [NumW-1:0]   num;
    logic [DistW-1:0]  den;
  } rd_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [NumW-1:0] value;
  } rd_rsp_t;

endpackage

@@ hdl/tdoa_ekf_measurement_builder.sv @@
// ----------------------------------------------------------------------------
// tdoa_ekf_measurement_builder
// Builds EKF measurement rows (Jacobian, measured, predicted, noise) for
// range-difference tag location from stored receiver and tag estimates.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall): one item per transfer. Loads of a
//   receiver, prior or posterior estimate are taken while idle and give
//   no result. A compute item raises in_stall until its last row is latched.
//   Output channel (out_valid/out_stall): one row per transfer, range rows
//   for the set mask bits in order 12, 23, 13, then the depth row with last.
//   Sequence: each of the three distances needs three bit-serial squares
//   and a serial root on the shared root/divide unit, then three serial
//   divides (skipped, giving a zero unit component, when the distance is
//   zero); each emitted row needs three serial products and an output step,
//   and a masked-off row is skipped.
//   A stalled row holds in the output register; the sequencer waits on it.
//   Reset clears stored positions and estimates to zero and both noise
//   variances to 1.0 (unsigned Q15.16). Configuration writes are registered.
// ----------------------------------------------------------------------------
module tdoa_ekf_measurement_builder (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [30:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [1:0]  receiver_index,
  input  logic signed [31:0] value_a,
  input  logic signed [31:0] value_b,
  input  logic signed [31:0] value_c,
  input  logic signed [31:0] tag_depth,
  input  logic [2:0]  valid_mask,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  row_index,
  output logic signed [18:0] jac_north,
  output logic signed [18:0] jac_east,
  output logic signed [18:0] jac_down,
  output logic signed [31:0] measured,
  output logic signed [31:0] predicted,
  output logic [31:0] noise_diag,
  output logic [30:0] noise_cross,
  output logic        is_depth_row,
  output logic        last
);
  import tekf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SQ_LD, S_SQ_RUN, S_SQRT, S_SQRT_WAIT, S_DIV_LD, S_DIV_WAIT,
    S_ERR_LD, S_ERR_RUN, S_ERR_ACC, S_EMIT
  } state_t;

  state_t state;

  // Stored positions, estimates and noise settings
  logic [31:0] rx [9];
  logic [31:0] prior [3];
  logic [31:0] post [3];
  logic [30:0] rng_var, dep_var;

  // Latched compute item
  logic [31:0] m_a, m_b, m_c, m_depth;
  logic [2:0]  mask;

  // Sequencer counters and serial datapath
  logic [1:0]       ri, ci, rk, n;
  logic [5:0]       bc;
  logic [RadW-1:0]  sumsq, mc;
  logic [32:0]      mr;
  logic [DistW-1:0] rdist [3];
  logic [17:0]      unit [3][3];
  logic [53:0]      acc;
  logic [50:0]      pr, pc;
  logic [17:0]      jm;
  logic             psign;

  rd_req_t req;
  rd_rsp_t rsp;

  tekf_root_div u_rd (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // Delta from prior to the selected receiver component
  logic [3:0]  rx_addr;
  logic [31:0] rx_sel, pri_sel, post_sel;
  logic [32:0] dl, dl_mag, dd, dd_mag;

  assign rx_addr  = 4'({ri, 1'b0}) + 4'(ri) + 4'(ci);
  assign rx_sel   = rx[rx_addr];
  assign pri_sel  = prior[ci];
  assign post_sel = post[ci];
  assign dl       = {rx_sel[31], rx_sel} - {pri_sel[31], pri_sel};
  assign dl_mag   = dl[32] ? (33'd0 - dl) : dl;
  assign dd       = {post_sel[31], post_sel} - {pri_sel[31], pri_sel};
  assign dd_mag   = dd[32] ? (33'd0 - dd) : dd;

  // Jacobian row for the current row slot
  logic [18:0] jr [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      case (rk)
        2'd0: jr[c] = {unit[1][c][17], unit[1][c]} - {unit[0][c][17], unit[0][c]};
        2'd1: jr[c] = {unit[2][c][17], unit[2][c]} - {unit[1][c][17], unit[1][c]};
        2'd2: jr[c] = {unit[2][c][17], unit[2][c]} - {unit[0][c][17], unit[0][c]};
        default: jr[c] = (c == 2) ? 19'd65536 : 19'd0;
      endcase
    end
  end

  logic [18:0] jsel;
  logic [17:0] jmag;
  assign jsel = jr[ci];
  assign jmag = 18'(jsel[18] ? (19'd0 - jsel) : jsel);

  // Predicted value with saturation
  logic [34:0] est;
  logic [37:0] err;
  logic [39:0] psum;
  logic [31:0] pred, meas, neg_c;

  always_comb begin
    case (rk)
      2'd0: est = {1'b0, rdist[0]} - {1'b0, rdist[1]};
      2'd1: est = {1'b0, rdist[1]} - {1'b0, rdist[2]};
      2'd2: est = {1'b0, rdist[0]} - {1'b0, rdist[2]};
      default: est = {{3{prior[2][31]}}, prior[2]};
    endcase
  end

  assign err  = acc[53:16];
  assign psum = {{5{est[34]}}, est} + {{2{err[37]}}, err};

  always_comb begin
    if (!psum[39] && (|psum[38:31]))
      pred = 32'h7fff_ffff;
    else if (psum[39] && !(&psum[38:31]))
      pred = 32'h8000_0000;
    else
      pred = psum[31:0];
  end

  assign neg_c = (m_c == 32'h8000_0000) ? 32'h7fff_ffff : (32'd0 - m_c);

  always_comb begin
    case (rk)
      2'd0: meas = m_a;
      2'd1: meas = m_b;
      2'd2: meas = neg_c;
      default: meas = m_depth;
    endcase
  end

  // Root/divide requests
  always_comb begin
    req.start = (state == S_SQRT) || ((state == S_DIV_LD) && (rdist[ri] != '0));
    req.op    = (state == S_SQRT) ? OP_SQRT : OP_DIV;
    req.rad   = sumsq;
    req.num   = {dl_mag, 16'd0};
    req.den   = rdist[ri];
  end

  assign in_stall = (state != S_IDLE);

  logic [31:0] vals [3];
  assign vals[0] = value_a;
  assign vals[1] = value_b;
  assign vals[2] = value_c;

  logic [17:0] qx;
  assign qx = {1'b0, rsp.value[16:0]};

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rng_var <= 31'd65536;
      dep_var <= 31'd65536;
    end else if (cfg_we) begin
      if (cfg_index == CFG_RANGE_VAR) rng_var <= cfg_data;
      if (cfg_index == CFG_DEPTH_VAR) dep_var <= cfg_data;
    end
  end

  // Sequencer, stores and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      for (int e = 0; e < 9; e++) rx[e] <= '0;
      for (int j = 0; j < 3; j++) begin
        prior[j] <= '0;
        post[j]  <= '0;
      end
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            case (action)
              ACT_LOAD_RX: begin
                for (int r = 0; r < 3; r++)
                  for (int j = 0; j < 3; j++)
                    if (receiver_index == 2'(r)) rx[r*3+j] <= vals[j];
              end
              ACT_LOAD_PRIOR: for (int j = 0; j < 3; j++) prior[j] <= vals[j];
              ACT_LOAD_POST:  for (int j = 0; j < 3; j++) post[j] <= vals[j];
              default: begin
                m_a     <= value_a;
                m_b     <= value_b;
                m_c     <= value_c;
                m_depth <= tag_depth;
                mask    <= valid_mask;
                ri      <= '0;
                ci      <= '0;
                sumsq   <= '0;
                state   <= S_SQ_LD;
              end
            endcase
          end
        end
        // sum of squares, one multiplier bit per cycle
        S_SQ_LD: begin
          mc    <= RadW'(dl_mag);
          mr    <= dl_mag;
          bc    <= 6'd32;
          state <= S_SQ_RUN;
        end
        S_SQ_RUN: begin
          if (mr[0]) sumsq <= sumsq + mc;
          mc <= {mc[RadW-2:0], 1'b0};
          mr <= {1'b0, mr[32:1]};
          bc <= bc - 6'd1;
          if (bc == 6'd0) begin
            if (ci == 2'd2) begin
              ci    <= '0;
              state <= S_SQRT;
            end else begin
              ci    <= ci + 2'd1;
              state <= S_SQ_LD;
            end
          end
        end
        S_SQRT: state <= S_SQRT_WAIT;
        S_SQRT_WAIT: begin
          if (rsp.done) begin
            rdist[ri] <= rsp.value[DistW-1:0];
            ci        <= '0;
            state     <= S_DIV_LD;
          end
        end
        // unit vector components; zero distance gives zero
        S_DIV_LD: begin
          if (rdist[ri] == '0) begin
            unit[ri][ci] <= '0;
            if (ci == 2'd2) begin
              ci <= '0;
              if (ri == 2'd2) begin
                rk    <= '0;
                n     <= '0;
                acc   <= '0;
                state <= S_ERR_LD;
              end else begin
                ri    <= ri + 2'd1;
                sumsq <= '0;
                state <= S_SQ_LD;
              end
            end else begin
              ci <= ci + 2'd1;
            end
          end else begin
            state <= S_DIV_WAIT;
          end
        end
        S_DIV_WAIT: begin
          if (rsp.done) begin
            unit[ri][ci] <= dl[32] ? (18'd0 - qx) : qx;
            if (ci == 2'd2) begin
              ci <= '0;
              if (ri == 2'd2) begin
                rk    <= '0;
                n     <= '0;
                acc   <= '0;
                state <= S_ERR_LD;
              end else begin
                ri    <= ri + 2'd1;
                sumsq <= '0;
                state <= S_SQ_LD;
              end
            end else begin
              ci    <= ci + 2'd1;
              state <= S_DIV_LD;
            end
          end
        end
        // stage error: jac . (posterior - prior), one jac bit per cycle
        S_ERR_LD: begin
          if (rk != 2'd3 && !mask[rk]) begin
            rk <= rk + 2'd1;
          end else begin
            pc    <= 51'(dd_mag);
            jm    <= jmag;
            psign <= jsel[18] ^ dd[32];
            pr    <= '0;
            bc    <= 6'd17;
            state <= S_ERR_RUN;
          end
        end
        S_ERR_RUN: begin
          if (jm[0]) pr <= pr + pc;
          pc <= {pc[49:0], 1'b0};
          jm <= {1'b0, jm[17:1]};
          bc <= bc - 6'd1;
          if (bc == 6'd0) state <= S_ERR_ACC;
        end
        S_ERR_ACC: begin
          acc <= acc + (psign ? (54'd0 - {3'b000, pr}) : {3'b000, pr});
          if (ci == 2'd2) begin
            ci    <= '0;
            state <= S_EMIT;
          end else begin
            ci    <= ci + 2'd1;
            state <= S_ERR_LD;
          end
        end
        // hand the row to the output register once it is free
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            row_index    <= n;
            jac_north    <= jr[0];
            jac_east     <= jr[1];
            jac_down     <= jr[2];
            measured     <= meas;
            predicted    <= pred;
            noise_diag   <= (rk == 2'd3) ? {1'b0, dep_var} : {rng_var, 1'b0};
            noise_cross  <= (rk == 2'd3) ? 31'd0 : rng_var;
            is_depth_row <= (rk == 2'd3);
            last         <= (rk == 2'd3);
            n            <= n + 2'd1;
            acc          <= '0;
            if (rk == 2'd3) begin
              state <= S_IDLE;
            end else begin
              rk    <= rk + 2'd1;
              state <= S_ERR_LD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_unit_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !rsp.busy)
    else $error("root/divide unit busy while sequencer idle");

  a_compute_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && action == ACT_COMPUTE) |=> in_stall)
    else $error("compute transfer did not block the input");

  a_last_depth: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == is_depth_row))
    else $error("last row is not the depth row");

  a_emit_wait: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_valid && out_stall) |=> (state == S_EMIT))
    else $error("row emitted over a stalled output");

endmodule

@@ hdl/tekf_root_div.sv @@
// ----------------------------------------------------------------------------
// tekf_root_div
// Bit-serial integer square root (one result bit per cycle) and restoring
// divider (one quotient bit per cycle), sharing one remainder register.
// ----------------------------------------------------------------------------
module tekf_root_div (
  input  logic              clk,
  input  logic              rst,
  input  tekf_pkg::rd_req_t req,
  output tekf_pkg::rd_rsp_t rsp
);
  import tekf_pkg::*;

  typedef enum logic [1:0] {U_IDLE, U_SQRT, U_DIV} ustate_t;

  ustate_t             st;
  rd_op_t              op;
  logic                done;
  logic [5:0]          cnt;
  logic [RadW+1:0]     rad;
  logic [36:0]         rem;
  logic [DistW-1:0]    root;
  logic [NumW-1:0]     dvd;
  logic [DistW-1:0]    den;

  // square root step: bring in two radicand bits, try (root<<2)|1
  logic [36:0] rem_s, trial;
  logic        sq_ge;
  // divide step: bring in one dividend bit, try the divisor
  logic [34:0] rem_d;
  logic        dv_ge;

  assign rem_s = {rem[34:0], rad[RadW+1:RadW]};
  assign trial = {1'b0, root, 2'b01};
  assign sq_ge = rem_s >= trial;
  assign rem_d = {rem[33:0], dvd[NumW-1]};
  assign dv_ge = rem_d >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= U_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (st)
        U_IDLE: begin
          if (req.start) begin
            op  <= req.op;
            rem <= '0;
            if (req.op == OP_SQRT) begin
              rad  <= {2'b00, req.rad};
              root <= '0;
              cnt  <= 6'd33;
              st   <= U_SQRT;
            end else begin
              dvd <= req.num;
              den <= req.den;
              cnt <= 6'd48;
              st  <= U_DIV;
            end
          end
        end
        U_SQRT: begin
          rem  <= sq_ge ? (rem_s - trial) : rem_s;
          root <= {root[DistW-2:0], sq_ge};
          rad  <= {rad[RadW-1:0], 2'b00};
          cnt  <= cnt - 6'd1;
          if (cnt == 6'd0) begin
            st   <= U_IDLE;
            done <= 1'b1;
          end
        end
        U_DIV: begin
          rem <= {2'b00, (dv_ge ? (rem_d - {1'b0, den}) : rem_d)};
          dvd <= {dvd[NumW-2:0], dv_ge};
          cnt <= cnt - 6'd1;
          if (cnt == 6'd0) begin
            st   <= U_IDLE;
            done <= 1'b1;
          end
        end
        default: st <= U_IDLE;
      endcase
    end
  end

  assign rsp.busy  = (st != U_IDLE);
  assign rsp.done  = done;
  assign rsp.value = (op == OP_SQRT) ? NumW'(root) : dvd;

endmodule
